>>> src/vpp_pkg.sv
// Package for the vector plane projection block.
// Shared widths and the record that travels through the divider cell row.
// No dependencies.
package vpp_pkg;

   localparam int unsigned COMP_W = 32;   // width of one vector component
   localparam int unsigned NN_W   = 64;   // squared normal length / divisor
   localparam int unsigned QUO_W  = 33;   // quotient bits, one per cell
   localparam int unsigned DVD_W  = NN_W + COMP_W;   // |D| * |n_i|
   localparam int unsigned TOL_W  = 16;

   typedef struct packed {
      logic                          valid;
      logic                          dflt;
      logic [2:0]                    qneg;
      logic [2:0][COMP_W-1:0]        vec;
      logic [NN_W-1:0]               dvsr;
      logic [2:0][NN_W-1:0]          rem;
      logic [2:0][QUO_W-1:0]         dvd;
      logic [2:0][QUO_W-1:0]         quo;
   } cell_type;

endpackage

>>> src/vpp_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on vpp_pkg for component widths.
interface vpp_req_if import vpp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COMP_W-1:0] vec_x;
   logic signed [COMP_W-1:0] vec_y;
   logic signed [COMP_W-1:0] vec_z;
   logic signed [COMP_W-1:0] norm_x;
   logic signed [COMP_W-1:0] norm_y;
   logic signed [COMP_W-1:0] norm_z;
   modport source (output valid, vec_x, vec_y, vec_z, norm_x, norm_y, norm_z, input ready);
   modport sink (input valid, vec_x, vec_y, vec_z, norm_x, norm_y, norm_z, output ready);
endinterface

interface vpp_rsp_if import vpp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COMP_W-1:0] proj_x;
   logic signed [COMP_W-1:0] proj_y;
   logic signed [COMP_W-1:0] proj_z;
   logic                     used_default_normal;
   logic                     saturated;
   modport source (output valid, proj_x, proj_y, proj_z, used_default_normal, saturated,
                   input ready);
   modport sink (input valid, proj_x, proj_y, proj_z, used_default_normal, saturated,
                 output ready);
endinterface

>>> src/vector_plane_projection.sv
// Top level of the vector plane projection block.
// Depends on vpp_pkg, vpp_if, vpp_front and vpp_cell.
//
// Usage:
//   req  : valid/ready channel carrying vector (vec_*) and plane normal
//          (norm_*), signed fixed point with FRAC_BITS fraction bits.
//   rsp  : valid/ready channel returning proj_*, used_default_normal and
//          saturated, one transfer per request transfer, in order.
//   csr  : csr_we/csr_wdata write zero_tolerance (reset value 1).
//          Write only while no request is in flight.
// Throughput: one transfer per cycle unless rsp stalls; all stages advance together.
// Pipeline: 5 front stages (products, sums, magnitude, partial products,
//   dividend build), 33 divider cells of one quotient bit each, and the
//   rounding/output register.
// Stall: when rsp is not taken the whole pipeline holds; req.ready drops
//   only while the output register is full and not being taken.
// Reset: synchronous, clears all stage valid bits and restores the
//   tolerance register; pipeline contents are dropped.
module vector_plane_projection import vpp_pkg::*; #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [TOL_W-1:0]     csr_wdata,
   vpp_req_if.sink              req,
   vpp_rsp_if.source            rsp
);

   logic [TOL_W-1:0] tol_ff;
   logic             en;

   cell_type         chain [QUO_W+1];

   // output register
   logic                     out_valid_ff;
   logic signed [COMP_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                     out_dflt_ff, out_sat_ff;
   logic [2:0][COMP_W-1:0]   res_in;
   logic                     sat_in;

   // advance whenever the output slot is free or being drained
   assign en        = !out_valid_ff || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(1);
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   vpp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req.valid),
      .in_vec   ({req.vec_z, req.vec_y, req.vec_x}),
      .in_norm  ({req.norm_z, req.norm_y, req.norm_x}),
      .tol      (tol_ff),
      .cout     (chain[0])
   );

   // row of divider cells, one quotient bit each
   for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      vpp_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .cin   (chain[k]),
         .cout  (chain[k+1])
      );
   end

   // round to nearest (ties away), apply sign, add to v, clamp
   always_comb begin
      cell_type last;
      last   = chain[QUO_W];
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         logic [QUO_W:0]  q;
         logic [NN_W-1:0] half;
         logic signed [QUO_W+2:0] s;
         half = last.dvsr - last.rem[i];
         q    = {1'b0, last.quo[i]} + ((last.rem[i] >= half) ? 34'd1 : 34'd0);
         if (last.qneg[i]) begin
            s = (QUO_W+3)'($signed(last.vec[i])) + $signed({2'b00, q});
         end else begin
            s = (QUO_W+3)'($signed(last.vec[i])) - $signed({2'b00, q});
         end
         if (s > (QUO_W+3)'(32'sh7fffffff)) begin
            res_in[i] = 32'h7fffffff;
            sat_in    = 1'b1;
         end else if (s < -(QUO_W+3)'(36'sh080000000)) begin
            res_in[i] = 32'h80000000;
            sat_in    = 1'b1;
         end else begin
            res_in[i] = s[COMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= chain[QUO_W].valid;
         out_dflt_ff  <= chain[QUO_W].dflt;
         if (chain[QUO_W].dflt) begin
            out_x_ff   <= chain[QUO_W].vec[0];
            out_y_ff   <= '0;
            out_z_ff   <= chain[QUO_W].vec[2];
            out_sat_ff <= 1'b0;
         end else begin
            out_x_ff   <= res_in[0];
            out_y_ff   <= res_in[1];
            out_z_ff   <= res_in[2];
            out_sat_ff <= sat_in;
         end
      end
   end

   assign rsp.valid               = out_valid_ff;
   assign rsp.proj_x              = out_x_ff;
   assign rsp.proj_y              = out_y_ff;
   assign rsp.proj_z              = out_z_ff;
   assign rsp.used_default_normal = out_dflt_ff;
   assign rsp.saturated           = out_sat_ff;

endmodule

>>> src/vpp_front.sv
// Front pipeline: dot products, squared length, tolerance test and numerators.
// Depends on vpp_pkg; feeds the first divider cell.
module vpp_front import vpp_pkg::*; #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [2:0][COMP_W-1:0]   in_vec,
   input  logic [2:0][COMP_W-1:0]   in_norm,
   input  logic [TOL_W-1:0]         tol,
   output cell_type                 cout
);

   // stage A: products
   logic                   a_valid_ff;
   logic [2:0][COMP_W-1:0] a_vec_ff, a_nmag_ff;
   logic [2:0]             a_nsgn_ff;
   logic [2:0][63:0]       a_prod_ff, a_sq_ff;
   // stage B: sums
   logic                   b_valid_ff;
   logic [2:0][COMP_W-1:0] b_vec_ff, b_nmag_ff;
   logic [2:0]             b_nsgn_ff;
   logic [NN_W-1:0]        b_nn_ff, b_pos_ff, b_neg_ff;
   logic [NN_W-1:0]        b_nn_in, b_pos_in, b_neg_in;
   // stage C: sign, magnitude, tolerance
   logic                   c_valid_ff, c_dflt_ff, c_dneg_ff;
   logic [2:0][COMP_W-1:0] c_vec_ff, c_nmag_ff;
   logic [2:0]             c_nsgn_ff;
   logic [NN_W-1:0]        c_nn_ff, c_dmag_ff;
   // stage D: partial products
   logic                   d_valid_ff, d_dflt_ff, d_dneg_ff;
   logic [2:0][COMP_W-1:0] d_vec_ff;
   logic [2:0]             d_nsgn_ff;
   logic [NN_W-1:0]        d_nn_ff;
   logic [2:0][63:0]       d_plo_ff, d_phi_ff;
   // stage E: cell record
   cell_type               e_ff, e_in;

   logic [NN_W-1:0] nn_scaled;
   assign nn_scaled = c_nn_in_shift(b_nn_ff);

   function automatic logic [NN_W-1:0] c_nn_in_shift(input logic [NN_W-1:0] x);
      c_nn_in_shift = x >> FRAC_BITS;
   endfunction

   always_comb begin
      b_nn_in  = '0;
      b_pos_in = '0;
      b_neg_in = '0;
      for (int i = 0; i < 3; i++) begin
         b_nn_in = b_nn_in + a_sq_ff[i];
         if (a_prod_ff[i][63]) begin
            b_neg_in = b_neg_in + (64'd0 - a_prod_ff[i]);
         end else begin
            b_pos_in = b_pos_in + a_prod_ff[i];
         end
      end
   end

   always_comb begin
      e_in       = '0;
      e_in.valid = d_valid_ff;
      e_in.dflt  = d_dflt_ff;
      e_in.vec   = d_vec_ff;
      e_in.dvsr  = d_nn_ff;
      for (int i = 0; i < 3; i++) begin
         logic [DVD_W-1:0] prod;
         prod         = {d_phi_ff[i], 32'd0} + {32'd0, d_plo_ff[i]};
         e_in.qneg[i] = d_dneg_ff ^ d_nsgn_ff[i];
         e_in.rem[i]  = {1'b0, prod[DVD_W-1:QUO_W]};
         e_in.dvd[i]  = prod[QUO_W-1:0];
         e_in.quo[i]  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_ff.valid <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         for (int i = 0; i < 3; i++) begin
            a_vec_ff[i]  <= in_vec[i];
            a_nsgn_ff[i] <= in_norm[i][COMP_W-1];
            a_nmag_ff[i] <= in_norm[i][COMP_W-1] ? (32'd0 - in_norm[i]) : in_norm[i];
            a_prod_ff[i] <= 64'($signed(in_vec[i]) * $signed(in_norm[i]));
            a_sq_ff[i]   <= 64'($signed(in_norm[i]) * $signed(in_norm[i]));
         end
         b_valid_ff <= a_valid_ff;
         b_vec_ff   <= a_vec_ff;
         b_nmag_ff  <= a_nmag_ff;
         b_nsgn_ff  <= a_nsgn_ff;
         b_nn_ff    <= b_nn_in;
         b_pos_ff   <= b_pos_in;
         b_neg_ff   <= b_neg_in;
         c_valid_ff <= b_valid_ff;
         c_vec_ff   <= b_vec_ff;
         c_nmag_ff  <= b_nmag_ff;
         c_nsgn_ff  <= b_nsgn_ff;
         c_nn_ff    <= b_nn_ff;
         c_dflt_ff  <= nn_scaled <= {48'd0, tol};
         c_dneg_ff  <= b_neg_ff > b_pos_ff;
         c_dmag_ff  <= (b_neg_ff > b_pos_ff) ? (b_neg_ff - b_pos_ff) : (b_pos_ff - b_neg_ff);
         d_valid_ff <= c_valid_ff;
         d_dflt_ff  <= c_dflt_ff;
         d_dneg_ff  <= c_dneg_ff;
         d_vec_ff   <= c_vec_ff;
         d_nsgn_ff  <= c_nsgn_ff;
         d_nn_ff    <= c_nn_ff;
         for (int i = 0; i < 3; i++) begin
            d_plo_ff[i] <= c_dmag_ff[31:0] * c_nmag_ff[i];
            d_phi_ff[i] <= c_dmag_ff[63:32] * c_nmag_ff[i];
         end
         e_ff <= e_in;
      end
   end

   assign cout = e_ff;

endmodule

>>> src/vpp_cell.sv
// One restoring-division cell: produces one quotient bit for all three lanes.
// Depends on vpp_pkg for the cell record.
module vpp_cell import vpp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  cell_type cin,
   output cell_type cout
);

   cell_type cell_ff, cell_in;

   always_comb begin
      cell_in = cin;
      for (int i = 0; i < 3; i++) begin
         logic [NN_W:0] trial;
         logic          ge;
         trial          = {cin.rem[i], cin.dvd[i][QUO_W-1]};
         ge             = trial >= {1'b0, cin.dvsr};
         cell_in.rem[i] = ge ? NN_W'(trial - {1'b0, cin.dvsr}) : trial[NN_W-1:0];
         cell_in.dvd[i] = {cin.dvd[i][QUO_W-2:0], 1'b0};
         cell_in.quo[i] = {cin.quo[i][QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cout = cell_ff;

endmodule
